### rtl/irpw_pkg.sv
package irpw_pkg;

  localparam int CMD_W    = 8;
  localparam int ADDR_W   = 4;
  localparam int CHK_W    = 4;
  localparam int BITS_W   = ADDR_W + CMD_W + CHK_W;
  localparam int DUR_W    = 13;
  localparam int FRAME_LEN = 19;
  localparam int IDX_W    = $clog2(FRAME_LEN);

  localparam logic [IDX_W-1:0] HDR_IDX   = IDX_W'(0);
  localparam logic [IDX_W-1:0] LEAD_IDX  = IDX_W'(1);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(FRAME_LEN - 1);
  localparam logic [IDX_W-1:0] BIT_BASE  = IDX_W'(BITS_W + 1);

  localparam logic [DUR_W-1:0] HDR_LONG_US  = DUR_W'(6000);
  localparam logic [DUR_W-1:0] HDR_SHORT_US = DUR_W'(3000);
  localparam logic [DUR_W-1:0] ONE_US       = DUR_W'(1200);
  localparam logic [DUR_W-1:0] ZERO_US      = DUR_W'(600);

  localparam logic [CHK_W-1:0] CHK_WEIGHT [CMD_W] = '{
    4'd14, 4'd7, 4'd10, 4'd5, 4'd6, 4'd3, 4'd2, 4'd1
  };

  typedef struct packed {
    logic [BITS_W-1:0] bits;
    logic              rep;
  } irpw_frame_t;

  // weights run from the command MSB down; sum kept mod 16
  function automatic logic [CHK_W-1:0] checksum_of(input logic [CMD_W-1:0] cmd);
    logic [CHK_W-1:0] sum;
    sum = '0;
    for (int i = 0; i < CMD_W; i++) begin
      if (cmd[CMD_W-1-i]) begin
        sum = sum + CHK_WEIGHT[i];
      end
    end
    return sum;
  endfunction

endpackage

### rtl/irpw_if.sv
interface irpw_cmd_if;
  import irpw_pkg::*;
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command_code;
  logic             repeat_frame;
  modport source (output valid, output command_code, output repeat_frame, input ready);
  modport sink   (input valid, input command_code, input repeat_frame, output ready);
endinterface

interface irpw_pulse_if;
  import irpw_pkg::*;
  logic             valid;
  logic             ready;
  logic             mark;
  logic [DUR_W-1:0] duration_us;
  logic             last;
  modport source (output valid, output mark, output duration_us, output last, input ready);
  modport sink   (input valid, input mark, input duration_us, input last, output ready);
endinterface

interface irpw_cfg_if;
  import irpw_pkg::*;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/ir_pulse_width_frame_encoder_core.sv
// Pulse-width IR frame encoder. Each cmd word (command code plus repeat flag)
// yields 19 frame words on the frame port: header mark (6000 us, 3000 us on a
// repeat), 1200 us space, 16 data elements MSB first (device address, command,
// checksum; 600 us for 0, 1200 us for 1), then a 600 us trailing mark flagged
// by last. Marks and spaces alternate starting with a mark. One frame word
// leaves per cycle while the frame port accepts it; the output element counter
// sets that rate. One further cmd word is buffered while a frame is being
// sent, so frames run back to back with no gap. device_address is sampled
// when a cmd word is taken; cfg is always ready.
module ir_pulse_width_frame_encoder_core
  import irpw_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  irpw_cfg_if.sink      cfg,
  irpw_cmd_if.sink      cmd,
  irpw_pulse_if.source  frame
);

  logic [ADDR_W-1:0] device_address;
  irpw_frame_t       pend;
  logic              pend_valid;
  logic              pend_take;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= '0;
    end else if (cfg.valid && cfg.ready) begin
      device_address <= cfg.data;
    end
  end

  irpw_frame_buf u_buf (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .device_address (device_address),
    .frame          (pend),
    .frame_valid    (pend_valid),
    .frame_take     (pend_take)
  );

  irpw_serializer u_ser (
    .clk         (clk),
    .rst         (rst),
    .frame       (pend),
    .frame_valid (pend_valid),
    .frame_take  (pend_take),
    .pulse       (frame)
  );

endmodule

### rtl/irpw_frame_buf.sv
module irpw_frame_buf
  import irpw_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  irpw_cmd_if.sink          cmd,
  input  logic [ADDR_W-1:0] device_address,
  output irpw_frame_t       frame,
  output logic              frame_valid,
  input  logic              frame_take
);

  logic pend_valid;

  assign cmd.ready   = !pend_valid || frame_take;
  assign frame_valid = pend_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (cmd.valid && cmd.ready) begin
      pend_valid <= 1'b1;
    end else if (frame_take) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      frame.bits <= {device_address, cmd.command_code, checksum_of(cmd.command_code)};
      frame.rep  <= cmd.repeat_frame;
    end
  end

endmodule

### rtl/irpw_serializer.sv
module irpw_serializer
  import irpw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  irpw_frame_t frame,
  input  logic        frame_valid,
  output logic        frame_take,
  irpw_pulse_if.source pulse
);

  logic              active;
  logic [IDX_W-1:0]  idx;
  irpw_frame_t       cur;
  logic              ov;
  logic              adv;
  logic [IDX_W-1:0]  bit_pos;
  logic [DUR_W-1:0]  dur;

  assign adv        = active && (!ov || pulse.ready);
  assign frame_take = frame_valid && (!active || (adv && idx == LAST_IDX));
  assign bit_pos    = BIT_BASE - idx;
  assign pulse.valid = ov;

  always_comb begin
    if (idx == HDR_IDX) begin
      dur = cur.rep ? HDR_SHORT_US : HDR_LONG_US;
    end else if (idx == LEAD_IDX) begin
      dur = ONE_US;
    end else if (idx == LAST_IDX) begin
      dur = ZERO_US;
    end else begin
      dur = cur.bits[bit_pos[$clog2(BITS_W)-1:0]] ? ONE_US : ZERO_US;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      idx    <= HDR_IDX;
      ov     <= 1'b0;
    end else begin
      if (frame_take) begin
        active <= 1'b1;
        idx    <= HDR_IDX;
      end else if (adv) begin
        if (idx == LAST_IDX) begin
          active <= 1'b0;
        end
        idx <= idx + IDX_W'(1);
      end
      if (adv) begin
        ov <= 1'b1;
      end else if (pulse.ready) begin
        ov <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (frame_take) begin
      cur <= frame;
    end
    if (adv) begin
      pulse.mark        <= ~idx[0];
      pulse.duration_us <= dur;
      pulse.last        <= (idx == LAST_IDX);
    end
  end

  a_last_is_mark: assert property (@(posedge clk) disable iff (rst)
    ov && pulse.last |-> pulse.mark)
    else $error("trailing word is not a mark");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    active |-> idx <= LAST_IDX)
    else $error("element index past end of frame");

  a_load_restart: assert property (@(posedge clk) disable iff (rst)
    frame_take |=> active && idx == HDR_IDX)
    else $error("new frame did not start at header");

  a_frame_end: assert property (@(posedge clk) disable iff (rst)
    adv && idx == LAST_IDX && !frame_valid |=> !active)
    else $error("serializer stayed busy after trailing mark");

endmodule

### tb/testbench.sv
module testbench;
  import irpw_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 40;

  typedef struct {
    logic             mark;
    logic [DUR_W-1:0] dur;
    logic             last;
  } pulse_word_t;

  logic clk = 1'b0;
  logic rst;

  irpw_cfg_if   cfg_bus ();
  irpw_cmd_if   cmd_bus ();
  irpw_pulse_if frame_bus ();

  ir_pulse_width_frame_encoder_core DUT (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg_bus),
    .cmd   (cmd_bus),
    .frame (frame_bus)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  pulse_word_t       pending_pulses[$];
  logic [ADDR_W-1:0] addr_shadow;
  int unsigned       cmd_idle_pct;
  int unsigned       pulse_stall_pct;
  int                err_cnt;
  int                quiet_cycles;

  function automatic logic [CHK_W-1:0] weighted_nibble(input logic [CMD_W-1:0] code);
    int          weights[CMD_W];
    logic [CHK_W-1:0] acc;
    weights = '{14, 7, 10, 5, 6, 3, 2, 1};
    acc = '0;
    for (int i = 0; i < CMD_W; i++) begin
      if (code[CMD_W-1-i]) begin
        acc = acc + CHK_W'(weights[i]);
      end
    end
    return acc;
  endfunction

  function automatic void queue_frame(input logic [CMD_W-1:0] code, input logic rep);
    logic [BITS_W-1:0] payload;
    pulse_word_t       w;
    payload = {addr_shadow, code, weighted_nibble(code)};
    for (int k = 0; k < FRAME_LEN; k++) begin
      w.mark = (k % 2 == 0);
      w.last = (k == FRAME_LEN - 1);
      if (k == 0) begin
        w.dur = rep ? DUR_W'(3000) : DUR_W'(6000);
      end else if (k == 1) begin
        w.dur = DUR_W'(1200);
      end else if (k == FRAME_LEN - 1) begin
        w.dur = DUR_W'(600);
      end else begin
        w.dur = payload[BITS_W + 1 - k] ? DUR_W'(1200) : DUR_W'(600);
      end
      pending_pulses.insert(pending_pulses.size(), w);
    end
  endfunction

  // leaves valid high on return; caller sends again or drains in the same step
  task automatic send_cmd(input logic [CMD_W-1:0] code, input logic rep);
    while ($urandom_range(99) < cmd_idle_pct) begin
      cmd_bus.valid        <= 1'b0;
      cmd_bus.command_code <= CMD_W'($urandom);
      cmd_bus.repeat_frame <= 1'($urandom);
      @(posedge clk);
    end
    cmd_bus.valid        <= 1'b1;
    cmd_bus.command_code <= code;
    cmd_bus.repeat_frame <= rep;
    do @(posedge clk); while (!cmd_bus.ready);
    queue_frame(code, rep);
  endtask

  task automatic drain();
    cmd_bus.valid <= 1'b0;
    while (pending_pulses.size() != 0) @(posedge clk);
  endtask

  task automatic write_address(input logic [ADDR_W-1:0] addr);
    drain();
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= addr;
    do @(posedge clk); while (!cfg_bus.ready);
    addr_shadow = addr;
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic test_reset_address();
    send_cmd(8'h00, 1'b0);
    send_cmd(8'hFF, 1'b1);
    send_cmd(8'hFF, 1'b0);
    send_cmd(8'h00, 1'b1);
    drain();
  endtask

  task automatic test_checksum_weights();
    write_address(4'hF);
    for (int i = 0; i < CMD_W; i++) begin
      send_cmd(CMD_W'(1) << i, 1'(i));
    end
    send_cmd(8'hAA, 1'b0);
    send_cmd(8'h55, 1'b1);
    drain();
  endtask

  task automatic test_address_extremes();
    write_address(4'h0);
    send_cmd(8'h7F, 1'b0);
    send_cmd(8'hFE, 1'b1);
    write_address(4'hA);
    send_cmd(8'h5A, 1'b0);
    send_cmd(8'hA5, 1'b1);
    write_address(4'hF);
    send_cmd(8'h00, 1'b0);
    send_cmd(8'hFF, 1'b1);
    write_address(4'h5);
    send_cmd(8'h81, 1'b0);
    send_cmd(8'h18, 1'b0);
    drain();
  endtask

  task automatic test_random_traffic(input int unsigned src_pct, input int unsigned snk_pct,
                                     input logic [ADDR_W-1:0] addr, input int count);
    logic [CMD_W-1:0] code;
    drain();
    cmd_idle_pct    = src_pct;
    pulse_stall_pct = snk_pct;
    write_address(addr);
    for (int n = 0; n < count; n++) begin
      code = CMD_W'($urandom);
      send_cmd(code, 1'b0);
      // a held key: first frame then a few repeats of the same code
      if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(3, 1)) send_cmd(code, 1'b1);
      end
      if ($urandom_range(15) == 0) begin
        write_address(ADDR_W'($urandom));
      end
    end
    drain();
  endtask

  always @(posedge clk) begin
    pulse_word_t w;
    if (!rst && frame_bus.valid && frame_bus.ready) begin
      if (pending_pulses.size() == 0) begin
        $display("%0t: unexpected word mark %0d dur %0d last %0d", $time,
                 frame_bus.mark, frame_bus.duration_us, frame_bus.last);
        err_cnt++;
      end else begin
        w = pending_pulses.pop_front();
        if (frame_bus.mark !== w.mark) begin
          $display("%0t: mark exp %0d got %0d", $time, w.mark, frame_bus.mark);
          err_cnt++;
        end
        if (frame_bus.duration_us !== w.dur) begin
          $display("%0t: duration_us exp %0d got %0d", $time, w.dur, frame_bus.duration_us);
          err_cnt++;
        end
        if (frame_bus.last !== w.last) begin
          $display("%0t: last exp %0d got %0d", $time, w.last, frame_bus.last);
          err_cnt++;
        end
      end
    end
    frame_bus.ready <= ($urandom_range(99) >= pulse_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (cmd_bus.valid && cmd_bus.ready) || (frame_bus.valid && frame_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: watchdog, no word moved for %0d cycles", $time, quiet_cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    rst                  = 1'b1;
    cmd_bus.valid        = 1'b0;
    cmd_bus.command_code = '0;
    cmd_bus.repeat_frame = 1'b0;
    cfg_bus.valid        = 1'b0;
    cfg_bus.data         = '0;
    frame_bus.ready      = 1'b0;
    addr_shadow          = '0;
    cmd_idle_pct         = 0;
    pulse_stall_pct      = 0;
    err_cnt              = 0;
    quiet_cycles         = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_address();
    test_checksum_weights();
    test_address_extremes();
    test_random_traffic(0, 0, 4'h0, 35);
    test_random_traffic(81, 0, 4'hF, 35);
    test_random_traffic(0, 81, ADDR_W'($urandom), 35);
    test_random_traffic(11, 11, ADDR_W'($urandom), 35);
    test_random_traffic(0, 0, 4'hF, 10);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_cnt == 0 && pending_pulses.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### sim.f
rtl/irpw_pkg.sv
rtl/irpw_if.sv
rtl/irpw_frame_buf.sv
rtl/irpw_serializer.sv
rtl/ir_pulse_width_frame_encoder_core.sv
tb/testbench.sv
